// ===== rtl/core/kfe_pkg.sv =====
// ----------------------------------------------------------------------------
// kfe_pkg
// Shared constants, register indexes and control structs of the keyframe
// envelope generator.
// ----------------------------------------------------------------------------
package kfe_pkg;

  localparam int MaxKeysDefault = 8;
  localparam int CfgIdxW        = 3;
  localparam int CfgDataW       = 64;
  localparam int TimeW          = 16;
  localparam int ValW           = 16;
  localparam int CountW         = 4;
  localparam int DivSteps       = 16;

  localparam logic [CfgIdxW-1:0] RegKeyCount = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDuration = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLoopMode = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKeys01   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKeys23   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegKeys45   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegKeys67   = 3'd6;

  typedef struct packed {
    logic [CountW-1:0] key_count;
    logic [TimeW-1:0]  duration;
    logic              loop_mode;
  } kfe_cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] ktime;
    logic [ValW-1:0]  kval;
  } kfe_key_t;

  typedef struct packed {
    logic                   start;
    logic [2*ValW-1:0]      dividend;
    logic [TimeW-1:0]       divisor;
  } kfe_div_req_t;

  typedef struct packed {
    logic            done;
    logic [ValW-1:0] quotient;
  } kfe_div_rsp_t;

endpackage

// ===== rtl/core/kfe_tick_if.sv =====
// ----------------------------------------------------------------------------
// kfe_tick_if
// Tick request channel: elapsed time since the previous tick.
// ----------------------------------------------------------------------------
interface kfe_tick_if;
  logic        valid;
  logic        ready;
  logic [15:0] delta;

  modport source (output valid, output delta, input ready);
  modport sink (input valid, input delta, output ready);
endinterface

// ===== rtl/core/kfe_result_if.sv =====
// ----------------------------------------------------------------------------
// kfe_result_if
// Result request channel: curve level, play position and finished flag.
// ----------------------------------------------------------------------------
interface kfe_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] level;
  logic [15:0] position;
  logic        finished;

  modport source (output valid, output level, output position, output finished, input ready);
  modport sink (input valid, input level, input position, input finished, output ready);
endinterface

// ===== rtl/core/keyframe_envelope_generator_unit.sv =====
// ----------------------------------------------------------------------------
// keyframe_envelope_generator_unit
// Tick-driven play position with a piecewise-linear keyframe curve.
// ----------------------------------------------------------------------------
// Each accepted tick advances the play position (wrap in loop mode, clamp and
// set the sticky finished flag in one-shot mode), then a sequencer scans the
// keyframes one per cycle through a single read port of the key store and,
// inside a segment, interpolates with one 16x16 multiply and a serial
// restoring divider. A tick goes from StLoad straight to StFinish when the
// curve ends early (no keys, one key, or at or before the first key), from
// StScan to StFinish when the scan runs off the last key, and through StMul
// and StDiv when it interpolates. A new tick is taken only when the sequencer
// is idle; a finished result waits in the output register while the next
// tick is being worked. Configuration must be written only while idle; the
// block itself has no check for this.
// ----------------------------------------------------------------------------
module keyframe_envelope_generator_unit import kfe_pkg::*; #(
  parameter int MAX_KEYS = MaxKeysDefault
) (
  input  logic                clk,
  input  logic                rst,
  kfe_tick_if.sink            tick,
  kfe_result_if.source        result,
  input  logic                wr_en,
  input  logic [CfgIdxW-1:0]  wr_index,
  input  logic [CfgDataW-1:0] wr_data
);

  localparam int IdxW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CntW = $clog2(MAX_KEYS + 1);

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StLoad   = 6'b000010,
    StScan   = 6'b000100,
    StMul    = 6'b001000,
    StDiv    = 6'b010000,
    StFinish = 6'b100000
  } state_t;

  state_t           state;
  kfe_cfg_t         cfg;
  kfe_key_t         key;
  kfe_div_req_t     div_req;
  kfe_div_rsp_t     div_rsp;

  logic [TimeW-1:0] play_position;
  logic             done_flag;
  logic [TimeW-1:0] t0;
  logic [ValW-1:0]  a;
  logic [IdxW-1:0]  idx;
  logic [IdxW-1:0]  rd_idx;
  logic [ValW-1:0]  diff;
  logic [TimeW-1:0] dlt;
  logic [TimeW-1:0] wdt;
  logic             neg;
  logic [ValW-1:0]  level;

  logic             out_valid;
  logic [ValW-1:0]  out_level;
  logic [TimeW-1:0] out_position;
  logic             out_finished;

  logic [CntW-1:0]  n_keys;
  logic [IdxW-1:0]  last_idx;
  logic [TimeW:0]   sum;
  logic             accept;
  logic             emit;

  kfe_cfg_regs #(.MAX_KEYS(MAX_KEYS)) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg),
    .rd_idx   (rd_idx),
    .key      (key)
  );

  kfe_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign n_keys   = (cfg.key_count > CountW'(MAX_KEYS)) ? CntW'(MAX_KEYS)
                                                        : CntW'(cfg.key_count);
  assign last_idx = IdxW'(n_keys - CntW'(1));
  assign sum      = {1'b0, play_position} + {1'b0, tick.delta};
  assign rd_idx   = (state == StScan) ? idx : '0;

  assign tick.ready = (state == StIdle);
  assign accept     = tick.valid && tick.ready;
  assign emit       = (state == StFinish) && (!out_valid || result.ready);

  assign div_req.start    = (state == StMul);
  assign div_req.dividend = (2*ValW)'(diff) * (2*ValW)'(dlt);
  assign div_req.divisor  = wdt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= StIdle;
      play_position <= '0;
      done_flag     <= 1'b0;
      idx           <= '0;
    end else begin
      unique case (state)
        StIdle: begin
          if (accept) begin
            if (sum >= {1'b0, cfg.duration}) begin
              if (cfg.loop_mode) begin
                play_position <= '0;
              end else begin
                play_position <= cfg.duration;
                done_flag     <= 1'b1;
              end
            end else begin
              play_position <= sum[TimeW-1:0];
            end
            state <= StLoad;
          end
        end
        StLoad: begin
          idx <= IdxW'(1);
          if (n_keys == '0 || n_keys == CntW'(1) || play_position <= key.ktime) begin
            state <= StFinish;
          end else begin
            state <= StScan;
          end
        end
        StScan: begin
          if (t0 <= play_position && play_position <= key.ktime) begin
            state <= (key.ktime == t0) ? StFinish : StMul;
          end else if (idx == last_idx) begin
            state <= StFinish;
          end else begin
            idx <= idx + IdxW'(1);
          end
        end
        StMul: begin
          state <= StDiv;
        end
        StDiv: begin
          if (div_rsp.done) begin
            state <= StFinish;
          end
        end
        StFinish: begin
          if (emit) begin
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      StLoad: begin
        t0 <= key.ktime;
        a  <= key.kval;
        level <= (n_keys == '0) ? '0 : key.kval;
      end
      StScan: begin
        if (t0 <= play_position && play_position <= key.ktime) begin
          level <= a;
          neg   <= key.kval < a;
          diff  <= (key.kval < a) ? a - key.kval : key.kval - a;
          dlt   <= play_position - t0;
          wdt   <= key.ktime - t0;
        end else begin
          level <= key.kval;
          t0    <= key.ktime;
          a     <= key.kval;
        end
      end
      StDiv: begin
        if (div_rsp.done) begin
          level <= neg ? a - div_rsp.quotient : a + div_rsp.quotient;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_level    <= level;
      out_position <= play_position;
      out_finished <= done_flag;
    end
  end

  assign result.valid    = out_valid;
  assign result.level    = out_level;
  assign result.position = out_position;
  assign result.finished = out_finished;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !tick.ready)
    else $error("tick taken while a request is in progress");

  a_finished_sticky: assert property (@(posedge clk) disable iff (rst)
    done_flag |=> done_flag)
    else $error("finished flag dropped without reset");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == StDiv)
    else $error("divider result outside the divide step");

  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> div_rsp.quotient <= diff)
    else $error("interpolation step exceeds segment span");
`endif

endmodule

// ===== rtl/core/kfe_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// kfe_cfg_regs
// Configuration registers and keyframe store with one indexed read port.
// ----------------------------------------------------------------------------
module kfe_cfg_regs import kfe_pkg::*; #(
  parameter int MAX_KEYS = MaxKeysDefault,
  localparam int IdxW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [CfgIdxW-1:0]  wr_index,
  input  logic [CfgDataW-1:0] wr_data,
  output kfe_cfg_t            cfg,
  input  logic [IdxW-1:0]     rd_idx,
  output kfe_key_t            key
);

  kfe_cfg_t cfg_r;
  kfe_key_t keys [MAX_KEYS];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        RegKeyCount: cfg_r.key_count <= wr_data[CountW-1:0];
        RegDuration: cfg_r.duration  <= wr_data[TimeW-1:0];
        RegLoopMode: cfg_r.loop_mode <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_KEYS; k++) begin
      if (rst) begin
        keys[k] <= '0;
      end else if (wr_en && wr_index == CfgIdxW'(int'(RegKeys01) + k / 2)) begin
        keys[k].ktime <= wr_data[(k % 2) * 32 +: TimeW];
        keys[k].kval  <= wr_data[(k % 2) * 32 + 16 +: ValW];
      end
    end
  end

  assign cfg = cfg_r;
  assign key = keys[rd_idx];

endmodule

// ===== rtl/core/kfe_divider.sv =====
// ----------------------------------------------------------------------------
// kfe_divider
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// 16 bits, so the upper dividend half is below the divisor at start.
// ----------------------------------------------------------------------------
module kfe_divider import kfe_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  kfe_div_req_t req,
  output kfe_div_rsp_t rsp
);

  localparam int StepW = $clog2(DivSteps);

  logic             busy;
  logic             done;
  logic [StepW-1:0] cnt;
  logic [ValW-1:0]  rem;
  logic [ValW-1:0]  lo;
  logic [TimeW-1:0] dvs;

  logic [ValW:0]    trial;
  logic [ValW:0]    trial_sub;
  logic             ge;

  assign trial     = {rem, lo[ValW-1]};
  assign ge        = trial >= {1'b0, dvs};
  assign trial_sub = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && cnt == '0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= StepW'(DivSteps - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - StepW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend[2*ValW-1:ValW];
      lo  <= req.dividend[ValW-1:0];
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= ge ? trial_sub[ValW-1:0] : trial[ValW-1:0];
      lo  <= {lo[ValW-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = lo;

endmodule
